[sv/pol_pkg.sv]
// Package for the positional ordered list: action, status and cell command codes.
// No dependencies; imported by the cell and the top level.
`timescale 1ns / 1ps

package pol_pkg;

   localparam int VALUE_W = 32;
   localparam int POS_W   = 6;
   localparam int COUNT_W = 6;
   // Compare width: covers a 6-bit position and an occupancy of up to 64
   localparam int CMP_W   = 7;

   typedef enum logic [1:0] {
      ACT_LOAD   = 2'd0,
      ACT_INSERT = 2'd1,
      ACT_DELETE = 2'd2,
      ACT_DUMP   = 2'd3
   } action_type;

   typedef enum logic [1:0] {
      STS_OK    = 2'd0,
      STS_RANGE = 2'd1,
      STS_FULL  = 2'd2,
      STS_EMPTY = 2'd3
   } status_type;

   typedef enum logic [2:0] {
      CELL_HOLD,
      CELL_APPEND,
      CELL_INSERT,
      CELL_DELETE,
      CELL_ROTATE
   } cell_op_type;

   // Command broadcast to every cell of the chain
   typedef struct packed {
      cell_op_type               op;
      logic [CMP_W-1:0]          pos;
      logic [CMP_W-1:0]          occ;
      logic signed [VALUE_W-1:0] value;
   } cell_cmd_type;

endpackage

[sv/pol_if.sv]
// Valid/ready channel interfaces for the request and response items.
// Depends on pol_pkg for field widths.
`timescale 1ns / 1ps

interface pol_req_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         action;
   logic signed [pol_pkg::VALUE_W-1:0] value;
   logic [pol_pkg::POS_W-1:0]          position;
   logic                               load_first;

   modport source (output valid, action, value, position, load_first, input ready);
   modport sink   (input valid, action, value, position, load_first, output ready);
endinterface

interface pol_rsp_if;
   logic                               valid;
   logic                               ready;
   logic [1:0]                         status;
   logic [pol_pkg::COUNT_W-1:0]        count;
   logic signed [pol_pkg::VALUE_W-1:0] element;
   logic                               last;

   modport source (output valid, status, count, element, last, input ready);
   modport sink   (input valid, status, count, element, last, output ready);
endinterface

[sv/pol_cell.sv]
// One storage cell of the list chain: holds one element and shifts with its neighbours.
// Depends on pol_pkg for the command struct.
`timescale 1ns / 1ps

module pol_cell #(
   parameter int IDX = 0
) (
   input  logic                               clock,
   input  pol_pkg::cell_cmd_type              cmd,
   input  logic signed [pol_pkg::VALUE_W-1:0] left_data,
   input  logic signed [pol_pkg::VALUE_W-1:0] right_data,
   input  logic signed [pol_pkg::VALUE_W-1:0] head_data,
   output logic signed [pol_pkg::VALUE_W-1:0] data
);
   import pol_pkg::*;

   localparam logic [CMP_W-1:0] IDX_C  = CMP_W'(IDX);
   localparam logic [CMP_W-1:0] IDX_N  = CMP_W'(IDX + 1);

   logic signed [VALUE_W-1:0] data_ff;
   logic signed [VALUE_W-1:0] data_in;

   // Choose the next content from the broadcast command and the cell's place
   always_comb begin
      data_in = data_ff;
      case (cmd.op)
         CELL_APPEND: begin
            if (IDX_C == cmd.occ) data_in = cmd.value;
         end
         CELL_INSERT: begin
            if (IDX_C == cmd.pos) begin
               data_in = cmd.value;
            end else if (IDX_C > cmd.pos && IDX_C <= cmd.occ) begin
               data_in = left_data;
            end
         end
         CELL_DELETE: begin
            if (IDX_N >= cmd.pos && IDX_N < cmd.occ) data_in = right_data;
         end
         CELL_ROTATE: begin
            if (IDX_N < cmd.occ) begin
               data_in = right_data;
            end else if (IDX_N == cmd.occ) begin
               data_in = head_data;
            end
         end
         default: data_in = data_ff;
      endcase
   end

   // Hold the element
   always_ff @(posedge clock) begin
      data_ff <= data_in;
   end

   assign data = data_ff;

endmodule

[sv/positional_ordered_list_core.sv]
// Positional ordered list: a chain of DEPTH cells, head in cell 0.
// Load, insert and delete write the cells and the result together; the result sits in the output register.
// Dump of n elements rotates the chain once per cycle while the output slot is free, giving n results;
// no item is accepted until the last dump result has been taken.
// Reset (synchronous, active high) empties the list and the output register;
// the cell contents are not cleared.
`timescale 1ns / 1ps

module positional_ordered_list_core #(
   parameter int DEPTH = 32
) (
   input  logic       clock,
   input  logic       reset,
   pol_req_if.sink    req_chan,
   pol_rsp_if.source  rsp_chan
);
   import pol_pkg::*;

   localparam int OW = $clog2(DEPTH + 1);
   localparam logic [CMP_W-1:0] DEPTH_C = CMP_W'(DEPTH);

   typedef enum logic [1:0] {
      ST_IDLE = 2'b01,
      ST_DUMP = 2'b10
   } state_type;

   state_type state_ff, state_in;
   logic [OW-1:0] occ_ff, occ_in;
   logic [OW-1:0] remain_ff, remain_in;

   logic                      rsp_valid_ff, rsp_valid_in;
   status_type                rsp_status_ff, rsp_status_in;
   logic [COUNT_W-1:0]        rsp_count_ff, rsp_count_in;
   logic signed [VALUE_W-1:0] rsp_element_ff, rsp_element_in;
   logic                      rsp_last_ff, rsp_last_in;

   cell_cmd_type              cmd;
   logic signed [VALUE_W-1:0] cell_data [DEPTH];

   logic             req_fire;
   logic             slot_free;
   logic [CMP_W-1:0] occ_c;
   logic [CMP_W-1:0] pos_c;
   logic [CMP_W-1:0] occ_eff;

   assign slot_free      = !rsp_valid_ff || rsp_chan.ready;
   assign req_chan.ready = (state_ff == ST_IDLE) && slot_free;
   assign req_fire       = req_chan.valid && req_chan.ready;
   assign occ_c          = CMP_W'(occ_ff);
   assign pos_c          = CMP_W'(req_chan.position);
   assign occ_eff        = req_chan.load_first ? '0 : occ_c;

   // Decode the item, drive the chain command and form the result
   always_comb begin
      cmd.op         = CELL_HOLD;
      cmd.pos        = pos_c;
      cmd.occ        = occ_c;
      cmd.value      = req_chan.value;
      occ_in         = occ_ff;
      state_in       = state_ff;
      remain_in      = remain_ff;
      rsp_valid_in   = rsp_valid_ff && !rsp_chan.ready;
      rsp_status_in  = rsp_status_ff;
      rsp_count_in   = rsp_count_ff;
      rsp_element_in = rsp_element_ff;
      rsp_last_in    = rsp_last_ff;

      if (req_fire) begin
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STS_OK;
         rsp_element_in = '0;
         rsp_last_in    = 1'b1;
         case (action_type'(req_chan.action))
            ACT_LOAD: begin
               cmd.occ = occ_eff;
               if (occ_eff >= DEPTH_C) begin
                  rsp_status_in = STS_FULL;
               end else begin
                  cmd.op = CELL_APPEND;
                  occ_in = OW'(occ_eff + 1'b1);
               end
            end
            ACT_INSERT: begin
               if (pos_c > occ_c) begin
                  rsp_status_in = STS_RANGE;
               end else if (occ_c >= DEPTH_C) begin
                  rsp_status_in = STS_FULL;
               end else begin
                  cmd.op = CELL_INSERT;
                  occ_in = occ_ff + 1'b1;
               end
            end
            ACT_DELETE: begin
               if (pos_c == '0 || pos_c > occ_c) begin
                  rsp_status_in = STS_RANGE;
               end else begin
                  cmd.op = CELL_DELETE;
                  occ_in = occ_ff - 1'b1;
               end
            end
            ACT_DUMP: begin
               if (occ_ff == '0) begin
                  rsp_status_in = STS_EMPTY;
               end else begin
                  rsp_valid_in = 1'b0;
                  state_in     = ST_DUMP;
                  remain_in    = occ_ff;
               end
            end
            default: rsp_status_in = STS_OK;
         endcase
         rsp_count_in = COUNT_W'(occ_in);
      end else if (state_ff == ST_DUMP && slot_free) begin
         // Emit the head and rotate the chain by one
         cmd.op         = CELL_ROTATE;
         rsp_valid_in   = 1'b1;
         rsp_status_in  = STS_OK;
         rsp_count_in   = COUNT_W'(occ_ff);
         rsp_element_in = cell_data[0];
         rsp_last_in    = (remain_ff == OW'(1));
         remain_in      = remain_ff - 1'b1;
         if (remain_ff == OW'(1)) state_in = ST_IDLE;
      end
   end

   // Build the chain of cells
   for (genvar g = 0; g < DEPTH; g++) begin : g_cell
      logic signed [VALUE_W-1:0] left_d;
      logic signed [VALUE_W-1:0] right_d;
      if (g == 0) begin : g_head
         assign left_d = cell_data[g];
      end else begin : g_body
         assign left_d = cell_data[g-1];
      end
      if (g == DEPTH - 1) begin : g_tail
         assign right_d = cell_data[g];
      end else begin : g_inner
         assign right_d = cell_data[g+1];
      end
      pol_cell #(
         .IDX (g)
      ) u_cell (
         .clock      (clock),
         .cmd        (cmd),
         .left_data  (left_d),
         .right_data (right_d),
         .head_data  (cell_data[0]),
         .data       (cell_data[g])
      );
   end

   // Control registers
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         occ_ff       <= '0;
         remain_ff    <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         occ_ff       <= occ_in;
         remain_ff    <= remain_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Output payload register
   always_ff @(posedge clock) begin
      rsp_status_ff  <= rsp_status_in;
      rsp_count_ff   <= rsp_count_in;
      rsp_element_ff <= rsp_element_in;
      rsp_last_ff    <= rsp_last_in;
   end

   assign rsp_chan.valid   = rsp_valid_ff;
   assign rsp_chan.status  = rsp_status_ff;
   assign rsp_chan.count   = rsp_count_ff;
   assign rsp_chan.element = rsp_element_ff;
   assign rsp_chan.last    = rsp_last_ff;

`ifndef SYNTH
   // Occupancy never exceeds the chain length
   assert property (@(posedge clock) disable iff (reset) occ_ff <= OW'(DEPTH))
      else $error("occupancy beyond depth");

   // Occupancy moves only when an item is accepted
   assert property (@(posedge clock) disable iff (reset) !req_fire |=> $stable(occ_ff))
      else $error("occupancy changed without an item");

   // A dump result carrying last ends the dump
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && slot_free && remain_ff == OW'(1)) |=>
         (state_ff == ST_IDLE && rsp_valid_ff && rsp_last_ff))
      else $error("dump did not finish on its last element");

   // While dumping, the count reported matches the occupancy
   assert property (@(posedge clock) disable iff (reset)
      (state_ff == ST_DUMP && slot_free) |=> rsp_count_ff == COUNT_W'(occ_ff))
      else $error("dump count mismatch");
`endif

endmodule
